### rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, widths, register indexes and helpers for the barometric
// pressure / temperature compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEFF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PRES_W    = 32;
    localparam int TEMP_W    = 19;

    localparam int FO_STAGES  = 3;
    localparam int SO_STAGES  = 4;
    localparam int PR_STAGES  = 5;
    localparam int NUM_STAGES = FO_STAGES + SO_STAGES + PR_STAGES;

    localparam logic [CFG_IDX_W-1:0] CFG_PRES_SENS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TCO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TCO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE = 3'd5;

    // 20.00 C and -15.00 C split points
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

    typedef struct packed {
        logic [COEFF_W-1:0] c1;
        logic [COEFF_W-1:0] c2;
        logic [COEFF_W-1:0] c3;
        logic [COEFF_W-1:0] c4;
        logic [COEFF_W-1:0] c5;
        logic [COEFF_W-1:0] c6;
    } coeff_t;

    // first-order results
    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp;
        logic signed [34:0]        off;
        logic signed [33:0]        sens;
        logic [16:0]               ti_low;
        logic [16:0]               ti_high;
    } fo_t;

    // second-order corrected terms
    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  t2;
        logic signed [38:0]        sc;
        logic signed [39:0]        oc;
    } so_t;

    // signed shift right that rounds toward zero
    function automatic logic signed [62:0] trunc_shr(input logic signed [62:0] x,
                                                     input int unsigned sh);
        logic signed [62:0] bias;
        bias = x[62] ? ((63'sd1 <<< sh) - 63'sd1) : 63'sd0;
        return (x + bias) >>> sh;
    endfunction

endpackage

`default_nettype wire

### rtl/ptc_first_order.sv
// ----------------------------------------------------------------------------
// ptc_first_order
// Stages 1-3: dT, coefficient products, first-order TEMP/OFF/SENS and both
// candidate temperature corrections.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_first_order (
    input  logic                              clk,
    input  logic [ptc_pkg::FO_STAGES-1:0]     en,
    input  ptc_pkg::coeff_t                   coeff,
    input  logic [ptc_pkg::RAW_W-1:0]         d1,
    input  logic [ptc_pkg::RAW_W-1:0]         d2,
    output ptc_pkg::fo_t                      fo
);

    logic [ptc_pkg::RAW_W-1:0]  s1_d1_reg;
    logic signed [24:0]         s1_dt_reg;
    logic signed [24:0]         s1_dt_next;

    logic [ptc_pkg::RAW_W-1:0]  s2_d1_reg;
    logic signed [41:0]         s2_pt_reg;
    logic signed [41:0]         s2_poff_reg;
    logic signed [41:0]         s2_psens_reg;
    logic [47:0]                s2_dt2_reg;
    logic [23:0]                dt_abs;

    logic [49:0]                dt2x3;
    ptc_pkg::fo_t               fo_reg;
    ptc_pkg::fo_t               fo_next;

    assign s1_dt_next = $signed({1'b0, d2}) - $signed({1'b0, coeff.c5, 8'h00});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_d1_reg <= d1;
            s1_dt_reg <= s1_dt_next;
        end
    end

    assign dt_abs = s1_dt_reg[24] ? 24'(-s1_dt_reg) : s1_dt_reg[23:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_d1_reg    <= s1_d1_reg;
            s2_pt_reg    <= s1_dt_reg * $signed({1'b0, coeff.c6});
            s2_poff_reg  <= s1_dt_reg * $signed({1'b0, coeff.c4});
            s2_psens_reg <= s1_dt_reg * $signed({1'b0, coeff.c3});
            s2_dt2_reg   <= dt_abs * dt_abs;
        end
    end

    assign dt2x3 = {2'b00, s2_dt2_reg} + {1'b0, s2_dt2_reg, 1'b0};

    always_comb
    begin
        fo_next.d1      = s2_d1_reg;
        fo_next.temp    = ptc_pkg::TEMP_REF
                        + 19'(ptc_pkg::trunc_shr(63'(s2_pt_reg), 23));
        fo_next.off     = $signed({1'b0, coeff.c2, 16'h0000})
                        + 35'(ptc_pkg::trunc_shr(63'(s2_poff_reg), 7));
        fo_next.sens    = $signed({1'b0, coeff.c1, 15'h0000})
                        + 34'(ptc_pkg::trunc_shr(63'(s2_psens_reg), 8));
        fo_next.ti_low  = dt2x3[49:33];
        fo_next.ti_high = {5'b0, s2_dt2_reg[47:36]};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            fo_reg <= fo_next;
        end
    end

    assign fo = fo_reg;

endmodule

`default_nettype wire

### rtl/ptc_second_order.sv
// ----------------------------------------------------------------------------
// ptc_second_order
// Stages 4-7: range split, squares, second-order offset and sensitivity
// corrections, saturated temperature.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_second_order (
    input  logic                              clk,
    input  logic [ptc_pkg::SO_STAGES-1:0]     en,
    input  ptc_pkg::fo_t                      fo,
    output ptc_pkg::so_t                      so
);

    logic                              low;
    logic                              vlow;
    logic [16:0]                       ti_sel;
    logic signed [19:0]                t_full;
    logic signed [ptc_pkg::TEMP_W-1:0] t_sat;
    logic [17:0]                       d_abs_next;
    logic [17:0]                       e_abs_next;

    logic [ptc_pkg::RAW_W-1:0]         s4_d1_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s4_t2_reg;
    logic signed [34:0]                s4_off_reg;
    logic signed [33:0]                s4_sens_reg;
    logic                              s4_low_reg;
    logic                              s4_vlow_reg;
    logic [17:0]                       s4_d_abs_reg;
    logic [17:0]                       s4_e_abs_reg;

    logic [ptc_pkg::RAW_W-1:0]         s5_d1_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s5_t2_reg;
    logic signed [34:0]                s5_off_reg;
    logic signed [33:0]                s5_sens_reg;
    logic                              s5_low_reg;
    logic                              s5_vlow_reg;
    logic [35:0]                       s5_dd_reg;
    logic [35:0]                       s5_ee_reg;

    logic [39:0]                       dd_w;
    logic [39:0]                       ee_w;
    logic [39:0]                       offi_next;
    logic [39:0]                       sensi_next;

    logic [ptc_pkg::RAW_W-1:0]         s6_d1_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s6_t2_reg;
    logic signed [34:0]                s6_off_reg;
    logic signed [33:0]                s6_sens_reg;
    logic [37:0]                       s6_offi_reg;
    logic [36:0]                       s6_sensi_reg;

    ptc_pkg::so_t                      so_reg;
    ptc_pkg::so_t                      so_next;

    // stage 4
    assign low    = fo.temp < ptc_pkg::TEMP_REF;
    assign vlow   = fo.temp < ptc_pkg::TEMP_VLOW;
    assign ti_sel = low ? fo.ti_low : fo.ti_high;
    assign t_full = 20'(fo.temp) - $signed({3'b000, ti_sel});
    assign t_sat  = (t_full[19] != t_full[18])
                  ? {t_full[19], {(ptc_pkg::TEMP_W-1){~t_full[19]}}}
                  : t_full[18:0];

    assign d_abs_next = low ? 18'(ptc_pkg::TEMP_REF - fo.temp)
                            : 18'(fo.temp - ptc_pkg::TEMP_REF);
    assign e_abs_next = vlow ? 18'(ptc_pkg::TEMP_VLOW - fo.temp) : 18'd0;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_d1_reg    <= fo.d1;
            s4_t2_reg    <= t_sat;
            s4_off_reg   <= fo.off;
            s4_sens_reg  <= fo.sens;
            s4_low_reg   <= low;
            s4_vlow_reg  <= vlow;
            s4_d_abs_reg <= d_abs_next;
            s4_e_abs_reg <= e_abs_next;
        end
    end

    // stage 5: squares
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_t2_reg   <= s4_t2_reg;
            s5_off_reg  <= s4_off_reg;
            s5_sens_reg <= s4_sens_reg;
            s5_low_reg  <= s4_low_reg;
            s5_vlow_reg <= s4_vlow_reg;
            s5_dd_reg   <= s4_d_abs_reg * s4_d_abs_reg;
            s5_ee_reg   <= s4_e_abs_reg * s4_e_abs_reg;
        end
    end

    // stage 6: corrections
    always_comb
    begin
        dd_w = 40'(s5_dd_reg);
        ee_w = 40'(s5_ee_reg);
        if (s5_low_reg)
        begin
            offi_next  = ((dd_w << 1) + dd_w) >> 1;
            sensi_next = ((dd_w << 2) + dd_w) >> 3;
            if (s5_vlow_reg)
            begin
                offi_next  = offi_next + ((ee_w << 3) - ee_w);
                sensi_next = sensi_next + (ee_w << 2);
            end
        end
        else
        begin
            offi_next  = dd_w >> 4;
            sensi_next = 40'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s6_d1_reg    <= s5_d1_reg;
            s6_t2_reg    <= s5_t2_reg;
            s6_off_reg   <= s5_off_reg;
            s6_sens_reg  <= s5_sens_reg;
            s6_offi_reg  <= offi_next[37:0];
            s6_sensi_reg <= sensi_next[36:0];
        end
    end

    // stage 7: corrected sensitivity and offset
    always_comb
    begin
        so_next.d1 = s6_d1_reg;
        so_next.t2 = s6_t2_reg;
        so_next.sc = 39'(s6_sens_reg) - 39'($signed({1'b0, s6_sensi_reg}));
        so_next.oc = 40'(s6_off_reg) - 40'($signed({1'b0, s6_offi_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            so_reg <= so_next;
        end
    end

    assign so = so_reg;

endmodule

`default_nettype wire

### rtl/ptc_pressure.sv
// ----------------------------------------------------------------------------
// ptc_pressure
// Stages 8-12: D1 x corrected sensitivity in two partial products, scaling,
// offset subtraction and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_pressure (
    input  logic                                     clk,
    input  logic [ptc_pkg::PR_STAGES-1:0]            en,
    input  ptc_pkg::so_t                             so,
    output logic signed [ptc_pkg::PRES_W-1:0]        pressure,
    output logic signed [ptc_pkg::TEMP_W-1:0]        temperature
);

    logic [43:0]                       s8_pp_lo_reg;
    logic signed [43:0]                s8_pp_hi_reg;
    logic signed [39:0]                s8_oc_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s8_t2_reg;

    logic signed [62:0]                s9_prod_reg;
    logic signed [39:0]                s9_oc_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s9_t2_reg;

    logic signed [41:0]                s10_q_reg;
    logic signed [39:0]                s10_oc_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s10_t2_reg;

    logic signed [42:0]                s11_diff_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] s11_t2_reg;

    logic signed [ptc_pkg::PRES_W-1:0] pressure_reg;
    logic signed [ptc_pkg::TEMP_W-1:0] temperature_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s8_pp_lo_reg <= so.d1 * so.sc[19:0];
            s8_pp_hi_reg <= $signed({1'b0, so.d1}) * $signed(so.sc[38:20]);
            s8_oc_reg    <= so.oc;
            s8_t2_reg    <= so.t2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s9_prod_reg <= (63'(s8_pp_hi_reg) <<< 20)
                         + 63'($signed({1'b0, s8_pp_lo_reg}));
            s9_oc_reg   <= s8_oc_reg;
            s9_t2_reg   <= s8_t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s10_q_reg  <= 42'(ptc_pkg::trunc_shr(s9_prod_reg, 21));
            s10_oc_reg <= s9_oc_reg;
            s10_t2_reg <= s9_t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s11_diff_reg <= 43'(s10_q_reg) - 43'(s10_oc_reg);
            s11_t2_reg   <= s10_t2_reg;
        end
    end

    // quotient spans at most 30 bits, so it always fits the 32-bit field
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            pressure_reg    <= 32'(ptc_pkg::trunc_shr(63'(s11_diff_reg), 13));
            temperature_reg <= s11_t2_reg;
        end
    end

    assign pressure    = pressure_reg;
    assign temperature = temperature_reg;

endmodule

`default_nettype wire

### rtl/pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Second-order temperature compensation of raw barometric conversions.
// Each item passes the first-order, second-order and pressure stages to out_valid.
// Throughput: one item per cycle; a stalled output holds the pipe, and empty
// stages still fill, so input is taken while a result waits unless all are full.
// Reset clears the stage valid bits and all coefficients to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temp_compensation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ptc_pkg::COEFF_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ptc_pkg::RAW_W-1:0]            raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]            raw_temperature,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ptc_pkg::PRES_W-1:0]    pressure_tenth_mbar,
    output logic signed [ptc_pkg::TEMP_W-1:0]    temperature_centi_deg
);

    localparam int N  = ptc_pkg::NUM_STAGES;
    localparam int FO = ptc_pkg::FO_STAGES;
    localparam int SO = ptc_pkg::SO_STAGES;

    ptc_pkg::coeff_t coeff_reg;
    logic [N-1:0]    valid_reg;
    logic [N-1:0]    valid_next;
    logic [N-1:0]    stage_en;
    ptc_pkg::fo_t    fo;
    ptc_pkg::so_t    so;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ptc_pkg::CFG_PRES_SENS:  coeff_reg.c1 <= cfg_data;
                ptc_pkg::CFG_PRES_OFF:   coeff_reg.c2 <= cfg_data;
                ptc_pkg::CFG_SENS_TCO:   coeff_reg.c3 <= cfg_data;
                ptc_pkg::CFG_OFF_TCO:    coeff_reg.c4 <= cfg_data;
                ptc_pkg::CFG_REF_TEMP:   coeff_reg.c5 <= cfg_data;
                ptc_pkg::CFG_TEMP_SLOPE: coeff_reg.c6 <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // a stage moves when the output drains or it or any later stage is empty
    for (genvar g = 0; g < N; g++)
    begin : g_en
        assign stage_en[g] = out_ready || !(&valid_reg[N-1:g]);
    end

    assign valid_next = {valid_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (stage_en & valid_next) | (~stage_en & valid_reg);
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[N-1];

    ptc_first_order u_first_order (
        .clk   (clk),
        .en    (stage_en[FO-1:0]),
        .coeff (coeff_reg),
        .d1    (raw_pressure),
        .d2    (raw_temperature),
        .fo    (fo)
    );

    ptc_second_order u_second_order (
        .clk (clk),
        .en  (stage_en[FO+SO-1:FO]),
        .fo  (fo),
        .so  (so)
    );

    ptc_pressure u_pressure (
        .clk         (clk),
        .en          (stage_en[N-1:FO+SO]),
        .so          (so),
        .pressure    (pressure_tenth_mbar),
        .temperature (temperature_centi_deg)
    );

    // items in flight track transfers in and out
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg))
                 + int'($past(in_valid && in_ready))
                 - int'($past(out_valid && out_ready)))
        else $error("pipeline occupancy mismatch");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transfer did not enter first stage");

endmodule

`default_nettype wire
